// ===== rtl/core/fha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
`default_nettype none
package fha_pkg;

	localparam int REQ_W    = 16;
	localparam int ADDR_W   = 16;
	localparam int GRANT_W  = 12;
	localparam int WASTE_W  = 13;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NO_FIT   = 3'd2,
		ST_OUTSIDE  = 3'd3,
		ST_DOUBLE   = 3'd4,
		ST_NO_BLOCK = 3'd5
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic look;
		logic pick;
		logic grant;
		logic mark;
		logic merge;
		logic rotate;
		logic out_load;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_free_op;
		logic req_zero;
		logic addr_zero;
		logic addr_out;
		logic any;
		logic sel_free;
		logic pair_any;
		logic rot_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/fha_datapath.sv =====
// block table cells, fit search, split, merge and fragmentation accumulators
`default_nettype none
module fha_datapath #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_BLOCKS   = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fha_pkg::dp_cmd_t              cmd,
	output fha_pkg::dp_stat_t                  stat,
	input  wire logic                          kind,
	input  wire logic [fha_pkg::REQ_W-1:0]     request_bytes,
	input  wire logic [fha_pkg::ADDR_W-1:0]    payload_address,
	output logic      [fha_pkg::GRANT_W-1:0]   granted_address,
	output logic      [fha_pkg::WASTE_W-1:0]   internal_waste,
	output logic      [fha_pkg::WASTE_W-1:0]   external_waste
);

	localparam int SW  = $clog2(HEAP_BYTES + 1);
	localparam int STW = $clog2(HEAP_BYTES);
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int XW  = ((SW > fha_pkg::REQ_W) ? SW : fha_pkg::REQ_W) + 2;
	localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
	localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);

	logic [STW-1:0]           start_q [MAX_BLOCKS];
	logic [SW-1:0]            size_q  [MAX_BLOCKS];
	logic [SW-1:0]            reqd_q  [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0]    free_q;
	logic [CW-1:0]            count_q;

	logic                     kind_q;
	logic [fha_pkg::REQ_W-1:0]  req_q;
	logic [fha_pkg::ADDR_W-1:0] addr_q;

	logic [MAX_BLOCKS-1:0]    match_q;
	logic [STW-1:0]           sel_start_q;
	logic [SW-1:0]            sel_size_q;
	logic                     sel_free_q;
	logic                     any_q;
	logic [STW-1:0]           granted_q;

	logic [CW-1:0]            rot_q;
	logic [SW-1:0]            total_q;
	logic [SW-1:0]            largest_q;
	logic [SW-1:0]            inner_q;

	logic [MAX_BLOCKS-1:0]    vld;
	logic [MAX_BLOCKS-1:0]    match_d;
	logic [MAX_BLOCKS-1:0]    win;
	logic [MAX_BLOCKS-1:0]    win_above;
	logic [MAX_BLOCKS-1:0]    pair;
	logic [MAX_BLOCKS-1:0]    pwin;
	logic [MAX_BLOCKS-1:0]    pwin_above;
	logic [STW-1:0]           pick_start;
	logic [SW-1:0]            pick_size;
	logic                     pick_free;
	logic                     split_ok;
	logic [STW-1:0]           new_start;
	logic [SW-1:0]            new_size;
	logic [XW-1:0]            req_x;

	assign req_x = XW'(req_q);

	always_comb begin
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			vld[k] = CW'(k) < count_q;
			if (kind_q == fha_pkg::KIND_ALLOC) begin
				match_d[k] = vld[k] && free_q[k] && (XW'(size_q[k]) >= req_x);
			end else begin
				match_d[k] = vld[k] && ((XW'(start_q[k]) + HDR_X) == XW'(addr_q));
			end
		end
	end

	// first set bit and everything above it
	assign win       = match_q & (~match_q + 1'b1);
	assign win_above = ~(win | (win - 1'b1));

	always_comb begin
		pick_start = '0;
		pick_size  = '0;
		pick_free  = 1'b0;
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			pick_start = pick_start | (start_q[k] & {STW{win[k]}});
			pick_size  = pick_size  | (size_q[k] & {SW{win[k]}});
			pick_free  = pick_free  | (free_q[k] & win[k]);
		end
	end

	assign split_ok  = (XW'(sel_size_q) >= (req_x + HDR_X + XW'(1))) && (count_q < MAX_C);
	assign new_start = STW'(XW'(sel_start_q) + HDR_X + req_x);
	assign new_size  = SW'(XW'(sel_size_q) - req_x - HDR_X);

	always_comb begin
		for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
			pair[k] = (CW'(k + 1) < count_q) && free_q[k] && free_q[k + 1];
		end
		pair[MAX_BLOCKS-1] = 1'b0;
	end

	assign pwin       = pair & (~pair + 1'b1);
	assign pwin_above = ~(pwin | (pwin - 1'b1));

	assign stat.is_free_op = (kind_q == fha_pkg::KIND_FREE);
	assign stat.req_zero   = (req_q == '0);
	assign stat.addr_zero  = (addr_q == '0);
	assign stat.addr_out   = (XW'(addr_q) >= HEAP_X);
	assign stat.any        = any_q;
	assign stat.sel_free   = sel_free_q;
	assign stat.pair_any   = |pair;
	assign stat.rot_last   = (rot_q == CW'(MAX_BLOCKS - 1));

	// block table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				start_q[k] <= '0;
				size_q[k]  <= '0;
				reqd_q[k]  <= '0;
			end
			size_q[0] <= SW'(HEAP_BYTES - HEADER_BYTES);
			free_q    <= MAX_BLOCKS'(1);
			count_q   <= CW'(1);
		end else if (cmd.grant) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				if (win[k]) begin
					free_q[k] <= 1'b0;
					reqd_q[k] <= SW'(req_q);
					if (split_ok) begin
						size_q[k] <= SW'(req_q);
					end
				end else if (split_ok && win_above[k] && k > 0) begin
					if (win[(k > 0) ? k - 1 : 0]) begin
						start_q[k] <= new_start;
						size_q[k]  <= new_size;
						free_q[k]  <= 1'b1;
						reqd_q[k]  <= '0;
					end else begin
						start_q[k] <= start_q[(k > 0) ? k - 1 : 0];
						size_q[k]  <= size_q[(k > 0) ? k - 1 : 0];
						free_q[k]  <= free_q[(k > 0) ? k - 1 : 0];
						reqd_q[k]  <= reqd_q[(k > 0) ? k - 1 : 0];
					end
				end
			end
			if (split_ok) begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.mark) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				if (win[k]) begin
					free_q[k] <= 1'b1;
					reqd_q[k] <= '0;
				end
			end
		end else if (cmd.merge && (|pair)) begin
			for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
				if (pwin[k]) begin
					size_q[k] <= SW'(XW'(size_q[k]) + HDR_X + XW'(size_q[k + 1]));
				end else if (pwin_above[k]) begin
					start_q[k] <= start_q[k + 1];
					size_q[k]  <= size_q[k + 1];
					free_q[k]  <= free_q[k + 1];
					reqd_q[k]  <= reqd_q[k + 1];
				end
			end
			count_q <= count_q - 1'b1;
		end else if (cmd.rotate) begin
			// cell 0 feeds the accumulators, table comes back after a full turn
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				start_q[k] <= start_q[(k + 1) % MAX_BLOCKS];
				size_q[k]  <= size_q[(k + 1) % MAX_BLOCKS];
				free_q[k]  <= free_q[(k + 1) % MAX_BLOCKS];
				reqd_q[k]  <= reqd_q[(k + 1) % MAX_BLOCKS];
			end
		end
	end

	// request latch, search registers and accumulators
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			req_q     <= request_bytes;
			addr_q    <= payload_address;
			granted_q <= '0;
			rot_q     <= '0;
			total_q   <= '0;
			largest_q <= '0;
			inner_q   <= '0;
		end
		if (cmd.look) begin
			match_q <= match_d;
		end
		if (cmd.pick) begin
			sel_start_q <= pick_start;
			sel_size_q  <= pick_size;
			sel_free_q  <= pick_free;
			any_q       <= |match_q;
		end
		if (cmd.grant) begin
			granted_q <= STW'(XW'(sel_start_q) + HDR_X);
		end
		if (cmd.rotate) begin
			rot_q <= rot_q + 1'b1;
			if (rot_q < count_q) begin
				if (free_q[0]) begin
					total_q <= total_q + size_q[0];
					if (size_q[0] > largest_q) begin
						largest_q <= size_q[0];
					end
				end else if (size_q[0] >= reqd_q[0]) begin
					inner_q <= inner_q + (size_q[0] - reqd_q[0]);
				end
			end
		end
		if (cmd.out_load) begin
			granted_address <= fha_pkg::GRANT_W'(granted_q);
			internal_waste  <= fha_pkg::WASTE_W'(inner_q);
			external_waste  <= (total_q == '0) ? '0 : fha_pkg::WASTE_W'(total_q - largest_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fha_ctrl.sv =====
// sequencing state machine of the heap allocator
`default_nettype none
module fha_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output fha_pkg::dp_cmd_t       cmd,
	input  wire fha_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_PICK,
		S_APPLY,
		S_MERGE,
		S_STATS,
		S_DONE
	} state_t;

	state_t            state_q;
	fha_pkg::status_t  status_q;
	logic              out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_LOOK:  cmd.look = 1'b1;
			S_PICK:  cmd.pick = 1'b1;
			S_APPLY: begin
				if (!stat.is_free_op) begin
					cmd.grant = !stat.req_zero && stat.any;
				end else begin
					cmd.mark = !stat.addr_zero && !stat.addr_out && stat.any && !stat.sel_free;
				end
			end
			S_MERGE: cmd.merge = 1'b1;
			S_STATS: cmd.rotate = 1'b1;
			S_DONE:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			status_q  <= fha_pkg::ST_OK;
			out_valid <= 1'b0;
			status    <= '0;
		end else begin
			// result word: load a new one or drop the one taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_PICK;
				S_PICK: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= S_STATS;
					if (!stat.is_free_op) begin
						if (stat.req_zero) begin
							status_q <= fha_pkg::ST_ZERO;
						end else if (!stat.any) begin
							status_q <= fha_pkg::ST_NO_FIT;
						end else begin
							status_q <= fha_pkg::ST_OK;
						end
					end else begin
						if (stat.addr_zero) begin
							status_q <= fha_pkg::ST_ZERO;
						end else if (stat.addr_out) begin
							status_q <= fha_pkg::ST_OUTSIDE;
						end else if (!stat.any) begin
							status_q <= fha_pkg::ST_NO_BLOCK;
						end else if (stat.sel_free) begin
							status_q <= fha_pkg::ST_DOUBLE;
						end else begin
							status_q <= fha_pkg::ST_OK;
							state_q  <= S_MERGE;
						end
					end
				end
				S_MERGE: begin
					if (!stat.pair_any) begin
						state_q <= S_STATS;
					end
				end
				S_STATS: begin
					if (stat.rot_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status    <= status_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// top level of the first-fit heap allocator with split and coalesce
// The block keeps a table of up to MAX_BLOCKS heap blocks in physical order,
// one register cell per entry. Each word on the input side is an allocate
// (kind 0, request_bytes) or a free (kind 1, payload_address); each produces
// exactly one result word with a status, the granted payload offset and the
// internal and external fragmentation after the operation. Items are taken
// one at a time; a successful free also merges adjacent free blocks, one pair
// at a time (at most two merges). The statistics pass rotates the whole table
// through cell 0 once, one entry per cycle, to sum wasted bytes and find the
// largest free block.
// The fit search itself is a parallel compare in every cell followed by a
// first-match pick; splits and merges shift all affected cells in the same cycle.
// A new word is accepted while the previous result still waits on the output.
`default_nettype none
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_BLOCKS   = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request word
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] payload_address,
	// result word
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [11:0]      granted_address,
	output logic [12:0]      internal_waste,
	output logic [12:0]      external_waste
);

	fha_pkg::dp_cmd_t  cmd;
	fha_pkg::dp_stat_t stat;

	// sequencer: search, apply, merge, statistics pass, result hand-off
	fha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.stat      (stat)
	);

	// block table and arithmetic
	fha_datapath #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.request_bytes   (request_bytes),
		.payload_address (payload_address),
		.granted_address (granted_address),
		.internal_waste  (internal_waste),
		.external_waste  (external_waste)
	);

endmodule
`default_nettype wire
